/* sv/mxy_pkg.sv */
`timescale 1ns / 1ps
package mxy_pkg;

  localparam int CFG_W   = 5;  // mesh size register width
  localparam int NODE_W  = 8;  // row-major node id width
  localparam int COORD_W = 5;  // column / row coordinate width
  localparam int IDX_W   = 2;  // config register index width

  localparam logic [IDX_W-1:0] REG_MESH_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MESH_HEIGHT = IDX_W'(1);

  localparam logic [CFG_W-1:0] MESH_WIDTH_RST  = CFG_W'(4);
  localparam logic [CFG_W-1:0] MESH_HEIGHT_RST = CFG_W'(4);

  // One classified route request, handed from the front to the back.
  typedef struct packed {
    logic               err;
    logic [NODE_W-1:0]  src;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
  } route_job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

/* sv/mxy_front.sv */
`timescale 1ns / 1ps
module mxy_front #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mxy_pkg::CFG_W-1:0]  mesh_width,
  input  logic [mxy_pkg::CFG_W-1:0]  mesh_height,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mxy_pkg::NODE_W-1:0] source_node,
  input  logic [mxy_pkg::NODE_W-1:0] target_node,
  output logic                       push,
  output mxy_pkg::route_job_t        push_job,
  input  logic                       q_full
);
  import mxy_pkg::*;

  localparam int STEP_W = $clog2(NODE_W);

  front_state_t        state, state_next;
  logic [STEP_W-1:0]   step;
  logic                err;
  logic [NODE_W-1:0]   src;
  logic [NODE_W-1:0]   div_s, div_d;   // dividend shifts out, quotient shifts in
  logic [COORD_W-1:0]  rem_s, rem_d;

  logic                accept;
  logic [2*CFG_W-1:0]  mesh_size;
  logic                bad_err;
  logic [COORD_W:0]    trial_s, trial_d;
  logic                ge_s, ge_d;

  assign accept    = in_valid && !in_stall;
  assign mesh_size = (2*CFG_W)'(mesh_width) * (2*CFG_W)'(mesh_height);
  assign bad_err   = (mesh_width == '0) || (mesh_height == '0)
                  || ({1'b0, mesh_width} > (CFG_W+1)'(MAX_WIDTH))
                  || ({1'b0, mesh_height} > (CFG_W+1)'(MAX_HEIGHT))
                  || ((2*CFG_W)'(source_node) >= mesh_size)
                  || ((2*CFG_W)'(target_node) >= mesh_size)
                  || (source_node == target_node);

  // restoring divide, one quotient bit per cycle for each id
  assign trial_s = {rem_s, div_s[NODE_W-1]};
  assign trial_d = {rem_d, div_d[NODE_W-1]};
  assign ge_s    = trial_s >= {1'b0, mesh_width};
  assign ge_d    = trial_d >= {1'b0, mesh_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err   <= bad_err;
      src   <= source_node;
      div_s <= source_node;
      div_d <= target_node;
      rem_s <= '0;
      rem_d <= '0;
      step  <= STEP_W'(NODE_W - 1);
    end else if (state == FR_DIV) begin
      div_s <= {div_s[NODE_W-2:0], ge_s};
      div_d <= {div_d[NODE_W-2:0], ge_d};
      rem_s <= ge_s ? COORD_W'(trial_s - {1'b0, mesh_width}) : trial_s[COORD_W-1:0];
      rem_d <= ge_d ? COORD_W'(trial_d - {1'b0, mesh_width}) : trial_d[COORD_W-1:0];
      step  <= step - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    push       = 1'b0;
    unique case (state)
      FR_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = bad_err ? FR_PUSH : FR_DIV;
        end
      end
      FR_DIV: begin
        if (step == '0) begin
          state_next = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // quotient fits a coordinate whenever the ids are in range
  always_comb begin
    push_job.err     = err;
    push_job.src     = src;
    push_job.src_col = rem_s;
    push_job.src_row = div_s[COORD_W-1:0];
    push_job.dst_col = rem_d;
    push_job.dst_row = div_d[COORD_W-1:0];
  end

endmodule

/* sv/mxy_fifo.sv */
`timescale 1ns / 1ps
module mxy_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mxy_pkg::route_job_t push_job,
  output logic                full,
  input  logic                pop,
  output mxy_pkg::route_job_t head_job,
  output logic                empty
);
  import mxy_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  route_job_t         mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

endmodule

/* sv/mxy_back.sv */
`timescale 1ns / 1ps
module mxy_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mxy_pkg::CFG_W-1:0]  mesh_width,
  input  mxy_pkg::route_job_t        head_job,
  input  logic                       q_empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mxy_pkg::NODE_W-1:0] node_id,
  output logic                       last_hop,
  output logic                       route_error
);
  import mxy_pkg::*;

  back_state_t         state, state_next;
  logic                err;
  logic [COORD_W-1:0]  col, row, dst_col, dst_row;
  logic [NODE_W-1:0]   node;

  logic                slot_free, emit, at_dst;

  assign slot_free = !out_valid || !out_stall;
  assign at_dst    = (col == dst_col) && (row == dst_row);
  assign emit      = (state == BK_RUN) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      node_id     <= err ? '0 : node;
      last_hop    <= err || at_dst;
      route_error <= err;
    end
    if (pop) begin
      err     <= head_job.err;
      node    <= head_job.src;
      col     <= head_job.src_col;
      row     <= head_job.src_row;
      dst_col <= head_job.dst_col;
      dst_row <= head_job.dst_row;
    end else if (emit) begin
      // X first, then Y
      if (col < dst_col) begin
        col  <= col + 1'b1;
        node <= node + 1'b1;
      end else if (col > dst_col) begin
        col  <= col - 1'b1;
        node <= node - 1'b1;
      end else if (row < dst_row) begin
        row  <= row + 1'b1;
        node <= node + NODE_W'(mesh_width);
      end else if (row > dst_row) begin
        row  <= row - 1'b1;
        node <= node - NODE_W'(mesh_width);
      end
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && (err || at_dst)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

endmodule

/* sv/mesh_xy_route_generator_core.sv */
`timescale 1ns / 1ps
// XY dimension-order route generator for a 2D mesh, node ids row-major.
// Input channel (in_valid / in_stall): one beat carries source_node and
//   target_node. The front latches the beat, checks both ids against the
//   configured mesh and splits them into column and row with a bit-serial
//   divider, then queues the job. It takes no new beat until that job is
//   pushed: accept, 8 divide steps, queue push, which waits while the queue
//   is full. A rejected beat skips the divider: accept, queue push.
// Output channel (out_valid / out_stall): one beat per route node, source
//   first, then along the row, then along the column; last_hop marks the
//   target. A bad request gives one beat: route_error = 1, last_hop = 1, node_id = 0.
// The back emits one node per cycle while the output is not stalled, and
//   pops the next job from the queue only once the last node of the route
//   has been emitted.
// A two-entry job queue sits between front and back, so a stalled receiver
//   stops only the back until the queue fills; the output register holds its
//   beat steady while out_stall is high.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 is
//   mesh_width, 1 is mesh_height; other indexes are dropped. Write only while
//   idle. Synchronous reset sets both sizes to 4 and empties the pipeline.
module mesh_xy_route_generator_core #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mxy_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mxy_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mxy_pkg::NODE_W-1:0] source_node,
  input  logic [mxy_pkg::NODE_W-1:0] target_node,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mxy_pkg::NODE_W-1:0] node_id,
  output logic                       last_hop,
  output logic                       route_error
);
  import mxy_pkg::*;

  logic [CFG_W-1:0] mesh_width, mesh_height;

  logic       push, q_full, q_empty, pop;
  route_job_t push_job, head_job;

  // config registers, no backpressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_width  <= MESH_WIDTH_RST;
      mesh_height <= MESH_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MESH_WIDTH) begin
        mesh_width <= cfg_data;
      end
      if (cfg_index == REG_MESH_HEIGHT) begin
        mesh_height <= cfg_data;
      end
    end
  end

  // front: accept, range check, split ids into column/row
  mxy_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .mesh_width  (mesh_width),
    .mesh_height (mesh_height),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .source_node (source_node),
    .target_node (target_node),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  // job queue decouples the two sides
  mxy_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // back: walk the route one node per beat
  mxy_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mesh_width  (mesh_width),
    .head_job    (head_job),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .node_id     (node_id),
    .last_hop    (last_hop),
    .route_error (route_error)
  );

endmodule

/* sv/mxy_checker.sv */
`timescale 1ns / 1ps
module mxy_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mxy_pkg::NODE_W-1:0] node_id,
  input logic                       last_hop,
  input logic                       route_error
);

  // held beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_id) && $stable(last_hop)
      && $stable(route_error))
    else $error("output beat changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && route_error |-> last_hop)
    else $error("error beat without last_hop");

  a_err_node: assert property (@(posedge clk) disable iff (rst)
    out_valid && route_error |-> node_id == '0)
    else $error("error beat with nonzero node_id");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind mesh_xy_route_generator_core mxy_checker u_mxy_checker (.*);
